### design/mctt_pkg.sv
// Shared types, request codes and sizing constants for the tick timer bank.
`default_nettype none

package mctt_pkg;

    // Number of timer channels in the bank.
    localparam int NUM_CHANNELS = 8;

    // Width of a channel index and of the allocation count.
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

    // Request codes as they arrive on the input channel.
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_ALLOC = 3'd1;
    localparam logic [2:0] REQ_SET   = 3'd2;
    localparam logic [2:0] REQ_START = 3'd3;
    localparam logic [2:0] REQ_STOP  = 3'd4;

    // Classified operations handed from the front end to the execution side.
    typedef enum logic [2:0] {
        OP_TICK,
        OP_ALLOC,
        OP_SET,
        OP_START,
        OP_STOP,
        OP_REJECT
    } op_t;

    // One input transaction.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  channel;
        logic        one_shot;
        logic [31:0] reload_ticks;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic       ok;
        logic [2:0] granted_channel;
        logic [7:0] fire_mask;
    } out_item_t;

    // Decoded command stored in the queue between front and back.
    typedef struct packed {
        op_t            op;
        logic [CH_W-1:0] chan;
        logic           one_shot;
        logic [31:0]    reload;
    } cmd_t;

endpackage

`default_nettype wire

### design/mctt_front.sv
// Front end: decodes a request and checks its channel number.
`default_nettype none

module mctt_front (
    input  mctt_pkg::in_item_t request,
    output mctt_pkg::cmd_t     cmd
);

    logic in_range;

    // A channel number is valid only below the size of the bank.
    assign in_range = (request.channel < 8'(mctt_pkg::NUM_CHANNELS));

    // Classify the request; set, start and stop on bad channels and unknown codes become rejects.
    always_comb
    begin
        cmd.chan     = request.channel[mctt_pkg::CH_W-1:0];
        cmd.one_shot = request.one_shot;
        cmd.reload   = request.reload_ticks;
        unique case (request.req_type)
            mctt_pkg::REQ_TICK:  cmd.op = mctt_pkg::OP_TICK;
            mctt_pkg::REQ_ALLOC: cmd.op = mctt_pkg::OP_ALLOC;
            mctt_pkg::REQ_SET:   cmd.op = in_range ? mctt_pkg::OP_SET : mctt_pkg::OP_REJECT;
            mctt_pkg::REQ_START: cmd.op = in_range ? mctt_pkg::OP_START : mctt_pkg::OP_REJECT;
            mctt_pkg::REQ_STOP:  cmd.op = in_range ? mctt_pkg::OP_STOP : mctt_pkg::OP_REJECT;
            default:             cmd.op = mctt_pkg::OP_REJECT;
        endcase
    end

endmodule

`default_nettype wire

### design/mctt_cmd_queue.sv
// Two-entry command queue between the front end and the execution side.
`default_nettype none

module mctt_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  mctt_pkg::cmd_t wr_cmd,
    output logic           full,
    input  logic           rd,
    output logic           empty,
    output mctt_pkg::cmd_t rd_cmd
);

    mctt_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           do_wr;
    logic           do_rd;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign rd_cmd = entry_reg[rd_ptr_reg];
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;

    // Storage needs no reset; only the pointers and the count do.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // Pointer and occupancy bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // The count never goes past the two entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("command queue count out of range");

    // A write without a read grows the queue by one.
    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("command queue lost a write");

    // With one entry held, the pointers are one apart.
    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("command queue pointers out of step");

endmodule

`default_nettype wire

### design/mctt_back.sv
// Execution side: holds the channel bank, walks it on ticks and registers results.
`default_nettype none

module mctt_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  mctt_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output mctt_pkg::out_item_t result
);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    localparam int N = mctt_pkg::NUM_CHANNELS;

    state_t                     state_reg, state_next;
    logic [mctt_pkg::CH_W-1:0]  idx_reg, idx_next;
    logic [7:0]                 mask_reg, mask_next;
    logic [mctt_pkg::CNT_W-1:0] alloc_reg, alloc_next;
    logic                       enable_reg [N];
    logic                       enable_next [N];
    logic                       one_shot_reg [N];
    logic                       one_shot_next [N];
    logic [31:0]                counter_reg [N];
    logic [31:0]                counter_next [N];
    logic [31:0]                reload_reg [N];
    logic [31:0]                reload_next [N];
    logic                       out_valid_reg, out_valid_next;
    mctt_pkg::out_item_t        out_item_reg, out_item_next;

    logic                       res_taken;
    logic                       slot_free;
    logic [31:0]                cnt_inc;
    logic                       walk_live;
    logic                       expire;
    logic [7:0]                 walk_mask;
    logic [mctt_pkg::CNT_W+2:0] alloc_ext;

    assign empty     = !out_valid_reg;
    assign result    = out_item_reg;
    assign res_taken = pop && out_valid_reg;
    assign slot_free = !out_valid_reg || res_taken;
    assign alloc_ext = {3'b000, alloc_reg};

    // Per-channel step of the tick walk: one add and one compare.
    assign walk_live = (mctt_pkg::CNT_W'(idx_reg) < alloc_reg) && enable_reg[idx_reg];
    assign cnt_inc   = counter_reg[idx_reg] + 32'd1;
    assign expire    = walk_live && (cnt_inc >= reload_reg[idx_reg]);
    assign walk_mask = expire ? (mask_reg | (8'd1 << idx_reg)) : mask_reg;

    // Next-state logic for the sequencer, the bank and the result slot.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        alloc_next     = alloc_reg;
        enable_next    = enable_reg;
        one_shot_next  = one_shot_reg;
        counter_next   = counter_reg;
        reload_next    = reload_reg;
        out_valid_next = res_taken ? 1'b0 : out_valid_reg;
        out_item_next  = out_item_reg;
        cmd_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop                       = 1'b1;
                    out_valid_next                = 1'b1;
                    out_item_next.ok              = 1'b1;
                    out_item_next.granted_channel = 3'd0;
                    out_item_next.fire_mask       = 8'd0;
                    unique case (cmd.op)
                        mctt_pkg::OP_TICK:
                        begin
                            // The result is posted at the end of the walk.
                            out_valid_next = 1'b0;
                            state_next     = ST_WALK;
                            idx_next       = '0;
                            mask_next      = 8'd0;
                        end
                        mctt_pkg::OP_ALLOC:
                        begin
                            if (alloc_reg < mctt_pkg::CNT_W'(N))
                            begin
                                out_item_next.granted_channel = alloc_ext[2:0];
                                alloc_next = alloc_reg + mctt_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                out_item_next.ok = 1'b0;
                            end
                        end
                        mctt_pkg::OP_SET:
                        begin
                            one_shot_next[cmd.chan] = cmd.one_shot;
                            reload_next[cmd.chan]   = cmd.reload;
                            counter_next[cmd.chan]  = 32'd0;
                            enable_next[cmd.chan]   = 1'b0;
                        end
                        mctt_pkg::OP_START:
                        begin
                            counter_next[cmd.chan] = 32'd0;
                            enable_next[cmd.chan]  = 1'b1;
                        end
                        mctt_pkg::OP_STOP:
                        begin
                            enable_next[cmd.chan] = 1'b0;
                        end
                        default:
                        begin
                            out_item_next.ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // Update the channel under the walk index.
                if (walk_live)
                begin
                    if (expire)
                    begin
                        counter_next[idx_reg] = 32'd0;
                        if (one_shot_reg[idx_reg])
                        begin
                            enable_next[idx_reg] = 1'b0;
                        end
                    end
                    else
                    begin
                        counter_next[idx_reg] = cnt_inc;
                    end
                end
                mask_next = walk_mask;
                if (idx_reg == mctt_pkg::CH_W'(N - 1))
                begin
                    state_next                    = ST_IDLE;
                    out_valid_next                = 1'b1;
                    out_item_next.ok              = 1'b1;
                    out_item_next.granted_channel = 3'd0;
                    out_item_next.fire_mask       = walk_mask;
                end
                else
                begin
                    idx_next = idx_reg + mctt_pkg::CH_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, channel bank and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            mask_reg      <= 8'd0;
            alloc_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
            for (int i = 0; i < N; i++)
            begin
                enable_reg[i]   <= 1'b0;
                one_shot_reg[i] <= 1'b0;
                counter_reg[i]  <= 32'd0;
                reload_reg[i]   <= 32'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            mask_reg      <= mask_next;
            alloc_reg     <= alloc_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
            enable_reg    <= enable_next;
            one_shot_reg  <= one_shot_next;
            counter_reg   <= counter_next;
            reload_reg    <= reload_next;
        end
    end

    // Commands are taken only between walks.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == ST_IDLE))
        else $error("command taken during a tick walk");

    // The allocation count never exceeds the bank size.
    a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_reg <= mctt_pkg::CNT_W'(N))
        else $error("allocation count past bank size");

    // The last walk step posts a tick result and returns to idle.
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && idx_reg == mctt_pkg::CH_W'(N - 1))
        |=> (state_reg == ST_IDLE && out_valid_reg && out_item_reg.ok))
        else $error("tick walk did not finish correctly");

endmodule

`default_nettype wire

### design/multi_channel_tick_timer_unit.sv
// Top level of the multi-channel tick timer: front end, command queue and execution side.
//
// Usage:
//   Requests enter through a queue-style port: a transaction is taken at a rising
//   edge with push high and full low. Each request produces exactly one result,
//   presented on result while empty is low and taken at an edge with pop high.
//   Requests are tick, allocate, set, start and stop; set, start and stop on a
//   channel outside the bank, allocate with no free channel and unknown codes
//   return ok low and change nothing.
// Timing:
//   A request is decoded in the cycle it is taken and written into a two-entry
//   command queue. Allocate, set, start, stop and rejects execute from the head of
//   the queue while the execution side is idle and its result slot is free; their
//   result is registered. A tick walks the channel bank one channel per cycle
//   through a single incrementer and comparator, busy until the last channel is done.
// Reset and stalls:
//   Reset clears all channels, modes, counters, reloads and the allocation count.
//   A result waits in its output register while pop is low; the execution side
//   then holds, the command queue fills, and full rises after two more requests.
`default_nettype none

module multi_channel_tick_timer_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mctt_pkg::in_item_t  request,
    output logic                empty,
    input  logic                pop,
    output mctt_pkg::out_item_t result
);

    mctt_pkg::cmd_t dec_cmd;
    mctt_pkg::cmd_t q_cmd;
    logic           q_empty;
    logic           q_rd;

    // Decode and range check of incoming requests.
    mctt_front u_front (
        .request (request),
        .cmd     (dec_cmd)
    );

    // Decoupling queue between decode and execution.
    mctt_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (push),
        .wr_cmd (dec_cmd),
        .full   (full),
        .rd     (q_rd),
        .empty  (q_empty),
        .rd_cmd (q_cmd)
    );

    // Channel bank, tick walk and result register.
    mctt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_cmd),
        .cmd_pop   (q_rd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
